// ----- hw/rtl/sip_pkg.sv -----
// Shared constants and outcome codes for the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

  localparam int COORD_W        = 16;
  localparam int MILLI_W        = 26;
  localparam int OUTCOME_W      = 3;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_PARALLEL = 3'd0,
    OC_SHARED   = 3'd1,
    OC_APART    = 3'd2,
    OC_PERP     = 3'd3,
    OC_DETZ     = 3'd4,
    OC_OFFSEG   = 3'd5,
    OC_HIT      = 3'd6
  } outcome_t;

endpackage

`default_nettype wire

// ----- hw/rtl/segment_intersection_point.sv -----
// Segment intersection: pipelined crossing test with milli-unit crossing point.
// Division: a restoring divider produces one quotient bit per stage.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_point #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sip_pkg::COORD_W-1:0]         in_a_start_x,
  input  logic [sip_pkg::COORD_W-1:0]         in_a_start_y,
  input  logic [sip_pkg::COORD_W-1:0]         in_a_end_x,
  input  logic [sip_pkg::COORD_W-1:0]         in_a_end_y,
  input  logic [sip_pkg::COORD_W-1:0]         in_b_start_x,
  input  logic [sip_pkg::COORD_W-1:0]         in_b_start_y,
  input  logic [sip_pkg::COORD_W-1:0]         in_b_end_x,
  input  logic [sip_pkg::COORD_W-1:0]         in_b_end_y,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [sip_pkg::MILLI_W-1:0]  out_cross_x_milli,
  output logic signed [sip_pkg::MILLI_W-1:0]  out_cross_y_milli,
  output logic [sip_pkg::OUTCOME_W-1:0]       out_outcome
);

  import sip_pkg::*;

  localparam int CW   = (COORD_BITS > COORD_W) ? COORD_W + 1 : COORD_BITS;
  localparam int AW   = CW + 1;
  localparam int CPW  = 2 * CW + 2;
  localparam int DW   = 2 * CW + 2;
  localparam int NW   = 3 * CW + 2;
  localparam int NNW  = 3 * CW + 14;
  localparam int DUW  = 2 * CW + 2;
  localparam int LW   = CW + 10;
  localparam int PW   = LW + DUW + 1;
  localparam int CMPW = 3 * CW + 15;
  localparam int QW   = CW + 10;
  localparam int RW   = QW + DUW;
  localparam int EW   = LW + 1 + MILLI_W;
  localparam int LAT  = QW + 7;

  localparam logic signed [NNW-1:0] K2000 = NNW'(2000);
  localparam logic signed [LW-1:0]  K1000 = LW'(1000);

  // ---------------- stage 0: coordinates and ordered early checks
  logic [COORD_W-1:0]   raw [8];
  logic signed [CW-1:0] cx  [8];

  assign raw[0] = in_a_start_x;
  assign raw[1] = in_a_start_y;
  assign raw[2] = in_a_end_x;
  assign raw[3] = in_a_end_y;
  assign raw[4] = in_b_start_x;
  assign raw[5] = in_b_start_y;
  assign raw[6] = in_b_end_x;
  assign raw[7] = in_b_end_y;

  for (genvar i = 0; i < 8; i++) begin : g_coord
    if (COORD_BITS > COORD_W) begin : g_wide
      assign cx[i] = $signed({1'b0, raw[i]});
    end else begin : g_narrow
      assign cx[i] = $signed(raw[i][CW-1:0]);
    end
  end

  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = cx[0];
  assign y1 = cx[1];
  assign x2 = cx[2];
  assign y2 = cx[3];
  assign x3 = cx[4];
  assign y3 = cx[5];
  assign x4 = cx[6];
  assign y4 = cx[7];

  logic signed [CW-1:0] ax_lo, ax_hi, ay_lo, ay_hi, bx_lo, bx_hi, by_lo, by_hi;
  logic signed [CW-1:0] xlo_nxt, xhi_nxt, ylo_nxt, yhi_nxt, px_nxt, py_nxt;
  logic                 early_nxt;
  outcome_t             code_nxt;
  logic                 vert_a, vert_b, horz_a, horz_b, shared, apart;

  always_comb begin
    vert_a = (x1 == x2);
    vert_b = (x3 == x4);
    horz_a = (y1 == y2);
    horz_b = (y3 == y4);
    shared = (x1 == x3 && y1 == y3) || (x2 == x4 && y2 == y4) ||
             (x1 == x4 && y1 == y4) || (x2 == x3 && y2 == y3);
    ax_lo = (x1 < x2) ? x1 : x2;
    ax_hi = (x1 > x2) ? x1 : x2;
    ay_lo = (y1 < y2) ? y1 : y2;
    ay_hi = (y1 > y2) ? y1 : y2;
    bx_lo = (x3 < x4) ? x3 : x4;
    bx_hi = (x3 > x4) ? x3 : x4;
    by_lo = (y3 < y4) ? y3 : y4;
    by_hi = (y3 > y4) ? y3 : y4;
    apart = (ax_hi < bx_lo) || (bx_hi < ax_lo) || (ay_hi < by_lo) || (by_hi < ay_lo);
    xlo_nxt = (ax_lo > bx_lo) ? ax_lo : bx_lo;
    xhi_nxt = (ax_hi < bx_hi) ? ax_hi : bx_hi;
    ylo_nxt = (ay_lo > by_lo) ? ay_lo : by_lo;
    yhi_nxt = (ay_hi < by_hi) ? ay_hi : by_hi;
    px_nxt  = (vert_a && horz_b) ? x1 : x3;
    py_nxt  = (vert_a && horz_b) ? y3 : y1;
    early_nxt = 1'b1;
    code_nxt  = OC_HIT;
    if ((vert_a && vert_b) || (horz_a && horz_b)) begin
      code_nxt = OC_PARALLEL;
    end else if (shared) begin
      code_nxt = OC_SHARED;
    end else if (apart) begin
      code_nxt = OC_APART;
    end else if ((vert_a && horz_b) || (horz_a && vert_b)) begin
      code_nxt = OC_PERP;
    end else begin
      early_nxt = 1'b0;
    end
  end

  logic                 s0_valid_r, s0_early_r;
  outcome_t             s0_code_r;
  logic signed [AW-1:0] s0_a1_r, s0_a2_r, s0_b1_r, s0_b2_r;
  logic signed [CW-1:0] s0_x1_r, s0_y1_r, s0_x3_r, s0_y3_r;
  logic signed [CW-1:0] s0_xlo_r, s0_xhi_r, s0_ylo_r, s0_yhi_r, s0_px_r, s0_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start;
    end
    s0_early_r <= early_nxt;
    s0_code_r  <= code_nxt;
    s0_a1_r    <= AW'(y2) - AW'(y1);
    s0_a2_r    <= AW'(y4) - AW'(y3);
    s0_b1_r    <= AW'(x1) - AW'(x2);
    s0_b2_r    <= AW'(x3) - AW'(x4);
    s0_x1_r    <= x1;
    s0_y1_r    <= y1;
    s0_x3_r    <= x3;
    s0_y3_r    <= y3;
    s0_xlo_r   <= xlo_nxt;
    s0_xhi_r   <= xhi_nxt;
    s0_ylo_r   <= ylo_nxt;
    s0_yhi_r   <= yhi_nxt;
    s0_px_r    <= px_nxt;
    s0_py_r    <= py_nxt;
  end

  // ---------------- stage 1: line constants and determinant
  logic                  s1_valid_r, s1_early_r;
  outcome_t              s1_code_r;
  logic signed [AW-1:0]  s1_a1_r, s1_a2_r, s1_b1_r, s1_b2_r;
  logic signed [CPW-1:0] s1_c1_r, s1_c2_r;
  logic signed [DW-1:0]  s1_det_r;
  logic signed [CW-1:0]  s1_xlo_r, s1_xhi_r, s1_ylo_r, s1_yhi_r, s1_px_r, s1_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
    s1_early_r <= s0_early_r;
    s1_code_r  <= s0_code_r;
    s1_a1_r    <= s0_a1_r;
    s1_a2_r    <= s0_a2_r;
    s1_b1_r    <= s0_b1_r;
    s1_b2_r    <= s0_b2_r;
    s1_c1_r    <= CPW'(s0_a1_r) * CPW'(s0_x1_r) + CPW'(s0_b1_r) * CPW'(s0_y1_r);
    s1_c2_r    <= CPW'(s0_a2_r) * CPW'(s0_x3_r) + CPW'(s0_b2_r) * CPW'(s0_y3_r);
    s1_det_r   <= DW'(s0_a1_r) * DW'(s0_b2_r) - DW'(s0_a2_r) * DW'(s0_b1_r);
    s1_xlo_r   <= s0_xlo_r;
    s1_xhi_r   <= s0_xhi_r;
    s1_ylo_r   <= s0_ylo_r;
    s1_yhi_r   <= s0_yhi_r;
    s1_px_r    <= s0_px_r;
    s1_py_r    <= s0_py_r;
  end

  // ---------------- stage 2: crossing numerators
  logic                 s2_valid_r, s2_early_r;
  outcome_t             s2_code_r;
  logic signed [NW-1:0] s2_nx_r, s2_ny_r;
  logic signed [DW-1:0] s2_det_r;
  logic signed [CW-1:0] s2_xlo_r, s2_xhi_r, s2_ylo_r, s2_yhi_r, s2_px_r, s2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_early_r <= s1_early_r;
    s2_code_r  <= s1_code_r;
    s2_nx_r    <= NW'(s1_b2_r) * NW'(s1_c1_r) - NW'(s1_b1_r) * NW'(s1_c2_r);
    s2_ny_r    <= NW'(s1_a1_r) * NW'(s1_c2_r) - NW'(s1_a2_r) * NW'(s1_c1_r);
    s2_det_r   <= s1_det_r;
    s2_xlo_r   <= s1_xlo_r;
    s2_xhi_r   <= s1_xhi_r;
    s2_ylo_r   <= s1_ylo_r;
    s2_yhi_r   <= s1_yhi_r;
    s2_px_r    <= s1_px_r;
    s2_py_r    <= s1_py_r;
  end

  // ---------------- stage 3: sign fold, rounding offset, box bounds in milli
  logic signed [DW-1:0]  dabs_nxt;
  logic signed [NW-1:0]  nxs_nxt, nys_nxt;
  logic                  detz_nxt;
  logic signed [CW-1:0]  lx_src, ly_src;

  always_comb begin
    detz_nxt = (s2_det_r == '0);
    if (s2_det_r < 0) begin
      dabs_nxt = -s2_det_r;
      nxs_nxt  = -s2_nx_r;
      nys_nxt  = -s2_ny_r;
    end else begin
      dabs_nxt = s2_det_r;
      nxs_nxt  = s2_nx_r;
      nys_nxt  = s2_ny_r;
    end
    lx_src = (s2_early_r && s2_code_r == OC_PERP) ? s2_px_r : s2_xlo_r;
    ly_src = (s2_early_r && s2_code_r == OC_PERP) ? s2_py_r : s2_ylo_r;
  end

  logic                  s3_valid_r, s3_done_r;
  outcome_t              s3_code_r;
  logic signed [NNW-1:0] s3_nx_r, s3_ny_r;
  logic [DUW-1:0]        s3_d_r;
  logic signed [LW-1:0]  s3_lx_r, s3_hx_r, s3_ly_r, s3_hy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_done_r <= s2_early_r || detz_nxt;
    s3_code_r <= s2_early_r ? s2_code_r : OC_DETZ;
    s3_nx_r   <= NNW'(nxs_nxt) * K2000 + NNW'(dabs_nxt);
    s3_ny_r   <= NNW'(nys_nxt) * K2000 + NNW'(dabs_nxt);
    s3_d_r    <= {dabs_nxt[DW-2:0], 1'b0};
    s3_lx_r   <= LW'(lx_src) * K1000;
    s3_ly_r   <= LW'(ly_src) * K1000;
    s3_hx_r   <= LW'(s2_xhi_r) * K1000 + LW'(1);
    s3_hy_r   <= LW'(s2_yhi_r) * K1000 + LW'(1);
  end

  // ---------------- stage 4: bounds scaled by the divisor
  logic signed [PW-1:0] dsig;
  assign dsig = PW'($signed({1'b0, s3_d_r}));

  logic                  s4_valid_r, s4_done_r;
  outcome_t              s4_code_r;
  logic signed [NNW-1:0] s4_nx_r, s4_ny_r;
  logic [DUW-1:0]        s4_d_r;
  logic signed [LW-1:0]  s4_lx_r, s4_ly_r;
  logic signed [PW-1:0]  s4_ldx_r, s4_hdx_r, s4_ldy_r, s4_hdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_done_r <= s3_done_r;
    s4_code_r <= s3_code_r;
    s4_nx_r   <= s3_nx_r;
    s4_ny_r   <= s3_ny_r;
    s4_d_r    <= s3_d_r;
    s4_lx_r   <= s3_lx_r;
    s4_ly_r   <= s3_ly_r;
    s4_ldx_r  <= PW'(s3_lx_r) * dsig;
    s4_hdx_r  <= PW'(s3_hx_r) * dsig;
    s4_ldy_r  <= PW'(s3_ly_r) * dsig;
    s4_hdy_r  <= PW'(s3_hy_r) * dsig;
  end

  // ---------------- stage 5: box test and divider dividend
  logic signed [CMPW-1:0] nxe, nye, rx_nxt, ry_nxt;
  logic                   inbox;
  outcome_t               code5_nxt;

  always_comb begin
    nxe    = CMPW'(s4_nx_r);
    nye    = CMPW'(s4_ny_r);
    inbox  = (nxe >= CMPW'(s4_ldx_r)) && (nxe < CMPW'(s4_hdx_r)) &&
             (nye >= CMPW'(s4_ldy_r)) && (nye < CMPW'(s4_hdy_r));
    rx_nxt = nxe - CMPW'(s4_ldx_r);
    ry_nxt = nye - CMPW'(s4_ldy_r);
    if (s4_done_r) begin
      code5_nxt = s4_code_r;
    end else if (inbox) begin
      code5_nxt = OC_HIT;
    end else begin
      code5_nxt = OC_OFFSEG;
    end
  end

  // ---------------- divider: one quotient bit per stage, remainder above quotient
  logic                 dv_valid_r [QW+1];
  outcome_t             dv_code_r  [QW+1];
  logic [RW-1:0]        dv_x_r     [QW+1];
  logic [RW-1:0]        dv_y_r     [QW+1];
  logic [DUW-1:0]       dv_d_r     [QW+1];
  logic signed [LW-1:0] dv_lx_r    [QW+1];
  logic signed [LW-1:0] dv_ly_r    [QW+1];

  function automatic logic [RW-1:0] div_step(input logic [RW-1:0] w, input logic [DUW-1:0] d);
    logic [DUW:0] trial;
    logic [DUW:0] diff;
    trial = {w[RW-1:QW], w[QW-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      return {diff[DUW-1:0], w[QW-2:0], 1'b1};
    end else begin
      return {trial[DUW-1:0], w[QW-2:0], 1'b0};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else begin
      dv_valid_r[0] <= s4_valid_r;
    end
    dv_code_r[0] <= code5_nxt;
    dv_x_r[0]    <= rx_nxt[RW-1:0];
    dv_y_r[0]    <= ry_nxt[RW-1:0];
    dv_d_r[0]    <= s4_d_r;
    dv_lx_r[0]   <= s4_lx_r;
    dv_ly_r[0]   <= s4_ly_r;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else begin
        dv_valid_r[k] <= dv_valid_r[k-1];
      end
      dv_code_r[k] <= dv_code_r[k-1];
      dv_x_r[k]    <= div_step(dv_x_r[k-1], dv_d_r[k-1]);
      dv_y_r[k]    <= div_step(dv_y_r[k-1], dv_d_r[k-1]);
      dv_d_r[k]    <= dv_d_r[k-1];
      dv_lx_r[k]   <= dv_lx_r[k-1];
      dv_ly_r[k]   <= dv_ly_r[k-1];
    end
  end

  // ---------------- output register
  logic signed [LW:0]        xsum, ysum, xsel, ysel;
  logic signed [EW-1:0]      xext, yext;
  outcome_t                  fin_code;

  always_comb begin
    fin_code = dv_code_r[QW];
    xsum = (LW + 1)'(dv_lx_r[QW]) + $signed({1'b0, dv_x_r[QW][QW-1:0]});
    ysum = (LW + 1)'(dv_ly_r[QW]) + $signed({1'b0, dv_y_r[QW][QW-1:0]});
    case (fin_code)
      OC_HIT: begin
        xsel = xsum;
        ysel = ysum;
      end
      OC_PERP: begin
        xsel = (LW + 1)'(dv_lx_r[QW]);
        ysel = (LW + 1)'(dv_ly_r[QW]);
      end
      default: begin
        xsel = '0;
        ysel = '0;
      end
    endcase
    xext = EW'(xsel);
    yext = EW'(ysel);
  end

  logic                      out_valid_r, out_hit_r;
  logic signed [MILLI_W-1:0] out_x_r, out_y_r;
  outcome_t                  out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid_r[QW];
    end
    out_hit_r  <= (fin_code == OC_HIT) || (fin_code == OC_PERP);
    out_x_r    <= xext[MILLI_W-1:0];
    out_y_r    <= yext[MILLI_W-1:0];
    out_code_r <= fin_code;
  end

  assign busy              = 1'b0;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_cross_x_milli = out_x_r;
  assign out_cross_y_milli = out_y_r;
  assign out_outcome       = out_code_r;

  // ---------------- checks
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_outcome == OC_PERP || out_outcome == OC_HIT))
    else $error("hit flagged with a non-hit outcome");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_cross_x_milli == '0 && out_cross_y_milli == '0))
    else $error("miss transaction carries a nonzero point");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT) out_valid)
    else $error("transaction lost in the pipeline");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire

// ----- tb/sip_checker.sv -----
// Checker: predicts segment crossing results and compares them with the block outputs.
`timescale 1ns / 1ps

module sip_checker #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [sip_pkg::COORD_W-1:0]        in_a_start_x,
  input  logic [sip_pkg::COORD_W-1:0]        in_a_start_y,
  input  logic [sip_pkg::COORD_W-1:0]        in_a_end_x,
  input  logic [sip_pkg::COORD_W-1:0]        in_a_end_y,
  input  logic [sip_pkg::COORD_W-1:0]        in_b_start_x,
  input  logic [sip_pkg::COORD_W-1:0]        in_b_start_y,
  input  logic [sip_pkg::COORD_W-1:0]        in_b_end_x,
  input  logic [sip_pkg::COORD_W-1:0]        in_b_end_y,
  input  logic                               out_valid,
  input  logic                               out_hit,
  input  logic signed [sip_pkg::MILLI_W-1:0] out_cross_x_milli,
  input  logic signed [sip_pkg::MILLI_W-1:0] out_cross_y_milli,
  input  logic [sip_pkg::OUTCOME_W-1:0]      out_outcome,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 crossing_count,
  output int                                 hit_count
);
  import sip_pkg::*;

  typedef struct packed {
    logic                      hit;
    logic [MILLI_W-1:0]        xm;
    logic [MILLI_W-1:0]        ym;
    outcome_t                  oc;
  } crossing_t;

  crossing_t expected_crossings[$];

  function automatic longint coord(logic [COORD_W-1:0] raw);
    longint v;
    v = longint'({1'b0, raw}) & ((64'sd1 <<< COORD_BITS) - 1);
    if (v[COORD_BITS-1]) v = v - (64'sd1 <<< COORD_BITS);
    return v;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint mn(longint p, longint q);
    return p < q ? p : q;
  endfunction

  function automatic longint mx(longint p, longint q);
    return p > q ? p : q;
  endfunction

  function automatic crossing_t mk(logic h, longint x, longint y, outcome_t oc);
    crossing_t r;
    r.hit = h;
    r.xm  = x[MILLI_W-1:0];
    r.ym  = y[MILLI_W-1:0];
    r.oc  = oc;
    return r;
  endfunction

  function automatic crossing_t predict_crossing(longint x1, longint y1, longint x2,
      longint y2, longint x3, longint y3, longint x4, longint y4);
    longint a1, a2, b1, b2, c1, c2, det, nx, ny, xm, ym;
    if ((x1 == x2 && x3 == x4) || (y1 == y2 && y3 == y4))
      return mk(1'b0, 0, 0, OC_PARALLEL);
    if ((x1 == x3 && y1 == y3) || (x2 == x4 && y2 == y4) ||
        (x1 == x4 && y1 == y4) || (x2 == x3 && y2 == y3))
      return mk(1'b0, 0, 0, OC_SHARED);
    if (mx(x1, x2) < mn(x3, x4) || mx(x3, x4) < mn(x1, x2) ||
        mx(y1, y2) < mn(y3, y4) || mx(y3, y4) < mn(y1, y2))
      return mk(1'b0, 0, 0, OC_APART);
    if (x1 == x2 && y3 == y4) return mk(1'b1, x1 * 1000, y3 * 1000, OC_PERP);
    if (y1 == y2 && x3 == x4) return mk(1'b1, x3 * 1000, y1 * 1000, OC_PERP);
    a1 = y2 - y1;
    a2 = y4 - y3;
    b1 = x1 - x2;
    b2 = x3 - x4;
    c1 = a1 * x1 + b1 * y1;
    c2 = a2 * x3 + b2 * y3;
    det = a1 * b2 - a2 * b1;
    if (det == 0) return mk(1'b0, 0, 0, OC_DETZ);
    nx = b2 * c1 - b1 * c2;
    ny = a1 * c2 - a2 * c1;
    if (det < 0) begin
      det = -det;
      nx = -nx;
      ny = -ny;
    end
    xm = fdiv(2000 * nx + det, 2 * det);
    ym = fdiv(2000 * ny + det, 2 * det);
    if (mn(x1, x2) * 1000 <= xm && xm <= mx(x1, x2) * 1000 &&
        mn(y1, y2) * 1000 <= ym && ym <= mx(y1, y2) * 1000 &&
        mn(x3, x4) * 1000 <= xm && xm <= mx(x3, x4) * 1000 &&
        mn(y3, y4) * 1000 <= ym && ym <= mx(y3, y4) * 1000)
      return mk(1'b1, xm, ym, OC_HIT);
    return mk(1'b0, 0, 0, OC_OFFSEG);
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    crossing_count = 0;
    hit_count = 0;
  end

  always @(posedge clk) begin
    crossing_t e;
    if (rst_n && start && !busy)
      expected_crossings.push_back(predict_crossing(coord(in_a_start_x),
          coord(in_a_start_y), coord(in_a_end_x), coord(in_a_end_y),
          coord(in_b_start_x), coord(in_b_start_y), coord(in_b_end_x),
          coord(in_b_end_y)));
    if (rst_n && out_valid) begin
      if (expected_crossings.size() == 0) begin
        fail_count <= fail_count + 1;
        $display("%0t: unexpected transaction, actual hit=%0b x=%0d y=%0d outcome=%0d",
                 $time, out_hit, out_cross_x_milli, out_cross_y_milli, out_outcome);
      end else begin
        e = expected_crossings.pop_front();
        crossing_count <= crossing_count + 1;
        if (e.hit) hit_count <= hit_count + 1;
        if (out_hit !== e.hit || out_cross_x_milli !== e.xm ||
            out_cross_y_milli !== e.ym || out_outcome !== e.oc) begin
          fail_count <= fail_count + 1;
          $display("%0t: mismatch expected hit=%0b x=%0d y=%0d outcome=%0d",
                   $time, e.hit, $signed(e.xm), $signed(e.ym), e.oc);
          $display("%0t:          actual   hit=%0b x=%0d y=%0d outcome=%0d",
                   $time, out_hit, out_cross_x_milli, out_cross_y_milli, out_outcome);
        end
      end
    end
    pending_count <= expected_crossings.size();
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives segment pairs into the crossing block and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
  import sip_pkg::*;

  localparam int CB = COORD_BITS_DEF;

  logic clk, rst_n, start, busy;
  logic [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic out_valid, out_hit;
  logic signed [MILLI_W-1:0] out_x, out_y;
  logic [OUTCOME_W-1:0] out_oc;
  int fail_count, pending_count, crossing_count, hit_count;

  segment_intersection_point #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_start_x(ax0), .in_a_start_y(ay0), .in_a_end_x(ax1), .in_a_end_y(ay1),
    .in_b_start_x(bx0), .in_b_start_y(by0), .in_b_end_x(bx1), .in_b_end_y(by1),
    .out_valid(out_valid), .out_hit(out_hit), .out_cross_x_milli(out_x),
    .out_cross_y_milli(out_y), .out_outcome(out_oc)
  );

  sip_checker #(.COORD_BITS(CB)) chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_start_x(ax0), .in_a_start_y(ay0), .in_a_end_x(ax1), .in_a_end_y(ay1),
    .in_b_start_x(bx0), .in_b_start_y(by0), .in_b_end_x(bx1), .in_b_end_y(by1),
    .out_valid(out_valid), .out_hit(out_hit), .out_cross_x_milli(out_x),
    .out_cross_y_milli(out_y), .out_outcome(out_oc), .fail_count(fail_count),
    .pending_count(pending_count), .crossing_count(crossing_count),
    .hit_count(hit_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  // hold start and operands until the block takes the transaction
  task automatic send_pair(int p0, int p1, int p2, int p3, int p4, int p5, int p6,
                           int p7);
    ax0 <= p0[COORD_W-1:0];
    ay0 <= p1[COORD_W-1:0];
    ax1 <= p2[COORD_W-1:0];
    ay1 <= p3[COORD_W-1:0];
    bx0 <= p4[COORD_W-1:0];
    by0 <= p5[COORD_W-1:0];
    bx1 <= p6[COORD_W-1:0];
    by1 <= p7[COORD_W-1:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic int rc(int span);
    return $urandom_range(2 * span, 0) - span;
  endfunction

  function automatic int rfull();
    return $urandom_range(65535, 0) - 32768;
  endfunction

  initial begin
    int span, cx, cy, burst, kind;
    start = 1'b0;
    rst_n = 1'b0;
    {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1} = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pair(0, 0, 0, 10, 5, 0, 5, 10);                // both vertical
    send_pair(0, 0, 10, 0, 0, 5, 10, 5);                // both horizontal
    send_pair(0, 0, 10, 10, 10, 10, 20, 0);             // shared endpoint
    send_pair(0, 0, 10, 10, 20, 20, 30, 25);            // boxes apart
    send_pair(5, -10, 5, 10, -10, 3, 10, 3);            // perpendicular
    send_pair(-10, 3, 10, 3, 5, -10, 5, 10);
    send_pair(0, 0, 10, 10, 2, 2, 12, 12);              // collinear overlap
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);              // hit
    send_pair(0, 0, 3, 7, 0, 5, 7, 0);                  // rounded hit
    send_pair(0, 0, 10, 1, 9, 10, 11, -10);             // hit
    send_pair(0, 0, 10, 2, 1, 10, 2, 9);                // boxes apart
    send_pair(3, 3, 3, 3, 0, 0, 8, 7);                  // zero-length
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    send_pair(32767, -32768, -32768, 32767, -32768, -32767, 32767, 32766);
    send_pair(-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767);
    send_pair(-1, -1, 1, 1, -1, 1, 1, -1);

    for (int n = 0; n < 2000;) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst; k++, n++) begin
        kind = $urandom_range(9, 0);
        span = kind < 3 ? 16 : (kind < 6 ? 1000 : 32767);
        cx = rc(32767 - span);
        cy = rc(32767 - span);
        if (kind == 9)
          send_pair(rfull(), rfull(), rfull(), rfull(), rfull(), rfull(), rfull(),
                    rfull());
        else if (kind == 8)
          send_pair(cx, cy - rc(span), cx, cy + rc(span), cx - rc(span), cy,
                    cx + rc(span), cy);
        else
          send_pair(cx + rc(span), cy + rc(span), cx + rc(span), cy + rc(span),
                    cx + rc(span), cy + rc(span), cx + rc(span), cy + rc(span));
      end
      if ($urandom_range(3, 0) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(12, 1)) @(negedge clk);
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("checked %0d crossing transactions, %0d of them hits", crossing_count,
             hit_count);
    $display("directed axis, shared, apart, collinear and extreme cases plus random pairs");
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
